[rtl/wsd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and defaults for the work-stealing deque core.
// No dependencies; used by every module of the block.
package wsd_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int MAX_BATCH_DEF = 16;

    localparam int KIND_W   = 2;
    localparam int WORD_W   = 64;
    localparam int LIMIT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH  = 2'd0,
        K_POP   = 2'd1,
        K_STEAL = 2'd2,
        K_BATCH = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture a new beat
        logic exec;   // run one access on the ring and pointers
        logic emit;   // drive one result beat
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic more;   // batch has further items to take
    } t_dp_stat;

endpackage

[rtl/wsd_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the work-stealing deque core.
// Depends on wsd_pkg (state enum, command and status structs).
module wsd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  wsd_pkg::t_dp_stat i_stat,
    output wsd_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);

    wsd_pkg::t_state r_state;
    wsd_pkg::t_state n_state;
    logic            busy;

    assign busy = (r_state == wsd_pkg::S_EXEC)
               || (r_state == wsd_pkg::S_EMIT && i_stat.more);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wsd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wsd_pkg::S_IDLE: begin
                if (i_start) n_state = wsd_pkg::S_EXEC;
            end
            wsd_pkg::S_EXEC: begin
                n_state = wsd_pkg::S_EMIT;
            end
            wsd_pkg::S_EMIT: begin
                if (i_stat.more || i_start) n_state = wsd_pkg::S_EXEC;
                else                        n_state = wsd_pkg::S_IDLE;
            end
            default: begin
                n_state = wsd_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_busy     = busy;
        o_cmd.load = i_start && !busy;
        o_cmd.exec = (r_state == wsd_pkg::S_EXEC);
        o_cmd.emit = (r_state == wsd_pkg::S_EMIT);
    end

endmodule

[rtl/wsd_dp.sv]
`timescale 1ns / 1ps
// Datapath of the work-stealing deque core: slot ring, pointers, result registers.
// Depends on wsd_pkg (codes, widths, command and status structs).
module wsd_dp #(
    parameter int DEPTH     = wsd_pkg::DEPTH_DEF,
    parameter int MAX_BATCH = wsd_pkg::MAX_BATCH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wsd_pkg::t_dp_cmd             i_cmd,
    output wsd_pkg::t_dp_stat            o_stat,
    input  logic [wsd_pkg::KIND_W-1:0]   i_kind,
    input  logic [wsd_pkg::WORD_W-1:0]   i_task_word,
    input  logic [wsd_pkg::LIMIT_W-1:0]  i_batch_limit,
    output logic                         o_valid,
    output logic [wsd_pkg::STATUS_W-1:0] o_status,
    output logic [wsd_pkg::WORD_W-1:0]   o_taken_word,
    output logic [wsd_pkg::OCC_W-1:0]    o_occupancy,
    output logic                         o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = AW + 1;
    localparam logic [PW-1:0] PTR_MAX = PW'(2 * DEPTH - 1);
    localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

    // ring storage, one write and one read port
    logic [wsd_pkg::WORD_W-1:0] mem [DEPTH];

    logic [PW-1:0]                r_top;
    logic [PW-1:0]                r_bot;
    wsd_pkg::t_kind               r_kind;
    logic [wsd_pkg::WORD_W-1:0]   r_word;
    logic [wsd_pkg::LIMIT_W-1:0]  r_left;
    logic [wsd_pkg::WORD_W-1:0]   r_rd_data;
    wsd_pkg::t_status             r_res_status;
    logic                         r_res_last;
    logic                         r_use_rd;
    logic                         r_more;

    logic                         r_o_valid;
    wsd_pkg::t_status             r_o_status;
    logic [wsd_pkg::WORD_W-1:0]   r_o_word;
    logic [wsd_pkg::OCC_W-1:0]    r_o_occ;
    logic                         r_o_last;

    logic [PW-1:0]                held;
    logic [PW-1:0]                top_inc;
    logic [PW-1:0]                bot_inc;
    logic [PW-1:0]                bot_dec;
    logic [AW-1:0]                top_slot;
    logic [AW-1:0]                bot_slot;
    logic [AW-1:0]                bdec_slot;
    logic [wsd_pkg::LIMIT_W-1:0]  sat_limit;

    assign held = (r_bot >= r_top)
                ? r_bot - r_top
                : PW'({1'b0, r_bot} + (PW + 1)'(2 * DEPTH) - {1'b0, r_top});

    assign top_inc = (r_top == PTR_MAX) ? '0 : r_top + 1'b1;
    assign bot_inc = (r_bot == PTR_MAX) ? '0 : r_bot + 1'b1;
    assign bot_dec = (r_bot == '0) ? PTR_MAX : r_bot - 1'b1;

    assign top_slot  = AW'((r_top   >= DEPTH_P) ? r_top   - DEPTH_P : r_top);
    assign bot_slot  = AW'((r_bot   >= DEPTH_P) ? r_bot   - DEPTH_P : r_bot);
    assign bdec_slot = AW'((bot_dec >= DEPTH_P) ? bot_dec - DEPTH_P : bot_dec);

    // saturate the batch limit; only narrows when MAX_BATCH is below the field range
    assign sat_limit = (32'(i_batch_limit) > 32'(MAX_BATCH))
                     ? wsd_pkg::LIMIT_W'(MAX_BATCH) : i_batch_limit;

    // capture the accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= wsd_pkg::t_kind'(i_kind);
            r_word <= i_task_word;
        end
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_kind == wsd_pkg::K_PUSH && r_word != '0
                && held < DEPTH_P) begin
            mem[bot_slot] <= r_word;
        end
        if (i_cmd.exec && held != '0) begin
            if (r_kind == wsd_pkg::K_POP) begin
                r_rd_data <= mem[bdec_slot];
            end else if (r_kind == wsd_pkg::K_STEAL
                    || (r_kind == wsd_pkg::K_BATCH && r_left != '0)) begin
                r_rd_data <= mem[top_slot];
            end
        end
    end

    // pointers and per-step result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top  <= '0;
            r_bot  <= '0;
            r_left <= '0;
            r_more <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_left <= sat_limit;
            end
            if (i_cmd.exec) begin
                r_more       <= 1'b0;
                r_res_last   <= 1'b1;
                r_use_rd     <= 1'b0;
                r_res_status <= wsd_pkg::ST_EMPTY;
                case (r_kind)
                    wsd_pkg::K_PUSH: begin
                        if (r_word == '0) begin
                            r_res_status <= wsd_pkg::ST_INVALID;
                        end else if (held >= DEPTH_P) begin
                            r_res_status <= wsd_pkg::ST_FULL;
                        end else begin
                            r_res_status <= wsd_pkg::ST_OK;
                            r_bot        <= bot_inc;
                        end
                    end
                    wsd_pkg::K_POP: begin
                        if (held != '0) begin
                            r_res_status <= wsd_pkg::ST_OK;
                            r_use_rd     <= 1'b1;
                            // the only item leaves through the top
                            if (held == PW'(1)) r_top <= top_inc;
                            else                r_bot <= bot_dec;
                        end
                    end
                    wsd_pkg::K_STEAL: begin
                        if (held != '0) begin
                            r_res_status <= wsd_pkg::ST_OK;
                            r_use_rd     <= 1'b1;
                            r_top        <= top_inc;
                        end
                    end
                    wsd_pkg::K_BATCH: begin
                        if (held != '0 && r_left != '0) begin
                            r_res_status <= wsd_pkg::ST_OK;
                            r_use_rd     <= 1'b1;
                            r_top        <= top_inc;
                            r_left       <= r_left - 1'b1;
                            r_res_last   <= (r_left == wsd_pkg::LIMIT_W'(1))
                                         || (held == PW'(1));
                            r_more       <= !((r_left == wsd_pkg::LIMIT_W'(1))
                                         || (held == PW'(1)));
                        end
                    end
                    default: begin
                        r_res_status <= wsd_pkg::ST_EMPTY;
                    end
                endcase
            end
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_o_status <= r_res_status;
            r_o_word   <= r_use_rd ? r_rd_data : '0;
            r_o_occ    <= wsd_pkg::OCC_W'(held);
            r_o_last   <= r_res_last;
        end
    end

    assign o_stat.more  = r_more;
    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_taken_word = r_o_word;
    assign o_occupancy  = r_o_occ;
    assign o_last       = r_o_last;

endmodule

[rtl/work_stealing_deque_core.sv]
`timescale 1ns / 1ps
// Top level of the work-stealing deque core: sequencer plus datapath.
// Depends on wsd_pkg, wsd_ctrl and wsd_dp.
//
// Usage:
//   Command channel: drive i_kind, i_task_word and i_batch_limit with start
//   high; the beat is taken at a rising edge where busy is low.  Kinds are
//   push bottom, pop bottom, steal top and steal batch.
//   Result channel: each result beat shows on o_status, o_taken_word,
//   o_occupancy and o_last for exactly one cycle with o_valid high.  The
//   receiver must take it then; there is no back-pressure.
//   Sequence: a command accepted at a rising edge runs its access step (EXEC),
//   then its emit step (EMIT), which loads the result register and o_valid.
//   A push, pop or steal runs one access step and one emit step; busy drops in
//   the cycle that loads the result register, so the next command can follow at once.
//   A batch steal runs one access step (ring access and pointer update) and one
//   emit step (result register load) per item taken, with busy high until the
//   last beat is loaded.  The sequencer alternates the two steps, so every item
//   costs both.
//   Reset: synchronous, active low; empties the deque (both pointers zero)
//   and clears o_valid.  Slot contents are not cleared.
module work_stealing_deque_core #(
    parameter int DEPTH     = wsd_pkg::DEPTH_DEF,
    parameter int MAX_BATCH = wsd_pkg::MAX_BATCH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [wsd_pkg::KIND_W-1:0]   i_kind,
    input  logic [wsd_pkg::WORD_W-1:0]   i_task_word,
    input  logic [wsd_pkg::LIMIT_W-1:0]  i_batch_limit,
    output logic                         o_valid,
    output logic [wsd_pkg::STATUS_W-1:0] o_status,
    output logic [wsd_pkg::WORD_W-1:0]   o_taken_word,
    output logic [wsd_pkg::OCC_W-1:0]    o_occupancy,
    output logic                         o_last
);

    wsd_pkg::t_dp_cmd  cmd;
    wsd_pkg::t_dp_stat stat;

    // sequencer: decides when to take a beat, access the ring and emit
    wsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath: slot ring, top/bottom pointers, result register
    wsd_dp #(
        .DEPTH     (DEPTH),
        .MAX_BATCH (MAX_BATCH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_kind        (i_kind),
        .i_task_word   (i_task_word),
        .i_batch_limit (i_batch_limit),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_taken_word  (o_taken_word),
        .o_occupancy   (o_occupancy),
        .o_last        (o_last)
    );

endmodule

[rtl/wsd_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the work-stealing deque core, bound to the top level.
// Depends on wsd_pkg (status codes) and work_stealing_deque_core.
module wsd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_valid,
    input logic [wsd_pkg::STATUS_W-1:0] o_status,
    input logic [wsd_pkg::WORD_W-1:0]   o_taken_word,
    input logic                         o_last
);

    // an accepted beat keeps the block busy for its ring access
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy low right after an accepted beat");

    // a batch beat that is not the last means more work is in flight
    a_busy_mid_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("mid-batch result while not busy");

    // failures carry no item
    a_fail_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != wsd_pkg::ST_OK |-> o_taken_word == '0)
        else $error("failed result carries an item");

    // a failure always ends its command
    a_fail_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != wsd_pkg::ST_OK |-> o_last)
        else $error("failed result not marked last");

    // result beats never come in back-to-back cycles
    a_beat_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beats in back-to-back cycles");

endmodule

bind work_stealing_deque_core wsd_checker u_wsd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_status     (o_status),
    .o_taken_word (o_taken_word),
    .o_last       (o_last)
);
